@@ hdl/gmps_pkg.sv @@
// Shared types, widths and register codes for the grid minimum path sum block.
package gmps_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  localparam int COST_W = 16;
  localparam int SUM_W  = 32;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 1;

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_idx_t;

  // Which neighbours feed the minimum for the current cell.
  typedef struct packed {
    logic has_up;
    logic has_left;
  } nbr_sel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sat;
  } cell_res_t;

endpackage

@@ hdl/gmps_if.sv @@
// Stream interfaces for cell costs in and path sums out.
interface gmps_cell_if import gmps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmps_res_if import gmps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] path_sum;
  logic             last_cell;
  logic             saturated;

  modport source (output valid, output path_sum, output last_cell, output saturated,
                  input ready);
  modport sink   (input valid, input path_sum, input last_cell, input saturated,
                  output ready);
endinterface

@@ hdl/grid_min_path_sum.sv @@
// Minimum right/down path sum over a grid streamed in row-major order. One cell
// is taken per clock cycle, back to back, unless stalled; its result enters the
// output register on the next cycle; input stalls only when it is full and
// not taken. The sums of the row above live in a one-port-write, one-port-read
// RAM of MAX_COLS entries whose read address always points at the next cell, so
// the value above is ready when that cell arrives; a one-column grid is served
// by forwarding the sum just written. No clearing pass is run after reset.
// Writing grid_cols or grid_rows restarts the grid at its top-left cell.
module grid_min_path_sum import gmps_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  gmps_cell_if.sink        cells,
  gmps_res_if.source       sums
);

  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);

  logic [CW-1:0]    grid_cols;
  logic [RCW-1:0]   grid_rows;
  logic [CW-1:0]    cols_wr;
  logic [RCW-1:0]   rows_wr;
  logic [31:0]      cfg_wide;

  logic [AW-1:0]    col, col_next;
  logic [RW-1:0]    row, row_next;
  logic [SUM_W-1:0] left_sum;
  logic             col_last, row_last;
  logic             accept;

  logic [SUM_W-1:0] ram_rdata;
  logic             fwd_hit;
  logic [SUM_W-1:0] fwd_data;
  logic [SUM_W-1:0] up_sum;
  nbr_sel_t         sel;
  cell_res_t        res;

  logic             out_valid;
  logic [SUM_W-1:0] out_sum;
  logic             out_last;
  logic             out_sat;

  assign accept      = cells.valid && cells.ready;
  assign cells.ready = !out_valid || sums.ready;

  // Clamp written sizes into 1..MAX
  always_comb begin
    cfg_wide = 32'(cfg_data);
    if (cfg_wide == 32'd0) begin
      cols_wr = CW'(1);
      rows_wr = RCW'(1);
    end else begin
      cols_wr = (cfg_wide > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cfg_wide);
      rows_wr = (cfg_wide > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(cfg_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= CW'(1);
      grid_rows <= RCW'(1);
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_COLS: grid_cols <= cols_wr;
        REG_GRID_ROWS: grid_rows <= rows_wr;
        default: ;
      endcase
    end
  end

  assign col_last = (CW'(col) + CW'(1)) >= grid_cols;
  assign row_last = (RCW'(row) + RCW'(1)) >= grid_rows;

  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg_wr_en) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (col_last) begin
        col_next = '0;
        row_next = row_last ? '0 : row + RW'(1);
      end else begin
        col_next = col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      left_sum <= '0;
      fwd_hit  <= 1'b0;
    end else begin
      col     <= col_next;
      row     <= row_next;
      // Forward when the next read hits the entry written this cycle
      fwd_hit <= accept && !cfg_wr_en && (col == col_next);
      if (cfg_wr_en) begin
        left_sum <= '0;
      end else if (accept) begin
        left_sum <= res.sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= res.sum;
  end

  gmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (res.sum),
    .raddr (col_next),
    .rdata (ram_rdata)
  );

  assign up_sum       = fwd_hit ? fwd_data : ram_rdata;
  assign sel.has_up   = (row != '0);
  assign sel.has_left = (col != '0);

  gmps_sum u_sum (
    .cost     (cells.cell_cost),
    .up_sum   (up_sum),
    .left_sum (left_sum),
    .sel      (sel),
    .res      (res)
  );

  // Output register: load on transaction, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (sums.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_sum  <= res.sum;
      out_last <= col_last && row_last;
      out_sat  <= res.sat;
    end
  end

  assign sums.valid     = out_valid;
  assign sums.path_sum  = out_sum;
  assign sums.last_cell = out_last;
  assign sums.saturated = out_sat;

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(col) < grid_cols)
    else $error("column pointer beyond grid width");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && col_last && row_last |=> (col == '0) && (row == '0))
    else $error("grid did not restart after its last cell");

  a_single_col_fwd: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_wr_en && (grid_cols == CW'(1)) |=> fwd_hit)
    else $error("one-column grid missed forwarding");

  a_sat_top: assert property (@(posedge clk) disable iff (rst)
    sums.valid && sums.saturated |-> (sums.path_sum == '1))
    else $error("saturated result not clipped to top");

endmodule

@@ hdl/gmps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/gmps_sum.sv @@
// Cell update: minimum of the neighbour sums plus the cell cost, saturating.
module gmps_sum import gmps_pkg::*; (
  input  logic [COST_W-1:0] cost,
  input  logic [SUM_W-1:0]  up_sum,
  input  logic [SUM_W-1:0]  left_sum,
  input  nbr_sel_t          sel,
  output cell_res_t         res
);

  logic [SUM_W-1:0] best;
  logic [SUM_W:0]   total;

  always_comb begin
    best = '0;
    if (sel.has_up && sel.has_left) begin
      best = (up_sum < left_sum) ? up_sum : left_sum;
    end else if (sel.has_up) begin
      best = up_sum;
    end else if (sel.has_left) begin
      best = left_sum;
    end
    total = {1'b0, best} + (SUM_W+1)'(cost);
    res.sat = total[SUM_W];
    res.sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
  end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the grid minimum path sum block.
module tb import gmps_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
    logic             sat;
  } path_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  reg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gmps_cell_if cells_ch ();
  gmps_res_if  sums_ch ();

  grid_min_path_sum dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells_ch),
    .sums      (sums_ch)
  );

  // Mirror of the block's state
  logic [SUM_W-1:0] above_sums [MAX_COLS_DEF] = '{default: '0};
  logic [SUM_W-1:0] left_sum = '0;
  int               col_pos = 0;
  int               row_pos = 0;
  int               cols_used = 1;
  int               rows_used = 1;

  path_result_t pending_sums [$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_rx = 1'b0;

  always #5 clk = ~clk;

  function automatic int dim_used(input logic [CFG_W-1:0] value, input int top);
    if (value == '0) return 1;
    if (value > top) return top;
    return int'(value);
  endfunction

  function automatic path_result_t next_path_sum(input logic [COST_W-1:0] cost);
    path_result_t     res;
    logic [SUM_W-1:0] best;
    logic [SUM_W:0]   total;
    best = '0;
    if (row_pos > 0 && col_pos > 0) begin
      best = (above_sums[col_pos] < left_sum) ? above_sums[col_pos] : left_sum;
    end else if (row_pos > 0) begin
      best = above_sums[col_pos];
    end else if (col_pos > 0) begin
      best = left_sum;
    end
    total   = {1'b0, best} + {{(SUM_W + 1 - COST_W){1'b0}}, cost};
    res.sat = total[SUM_W];
    res.sum = res.sat ? '1 : total[SUM_W-1:0];
    above_sums[col_pos] = res.sum;
    left_sum            = res.sum;
    res.last = (row_pos + 1 >= rows_used) && (col_pos + 1 >= cols_used);
    col_pos++;
    if (col_pos >= cols_used) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows_used) row_pos = 0;
    end
    return res;
  endfunction

  // Offer one cost; record the expected sum on the accepting edge
  task automatic send_cost(input logic [COST_W-1:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      cells_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cells_ch.valid     <= 1'b1;
    cells_ch.cell_cost <= cost;
    @(posedge clk);
    while (!cells_ch.ready) @(posedge clk);
    pending_sums.push_back(next_path_sum(cost));
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding sum has come back
  task automatic wait_idle();
    cells_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_GRID_COLS) cols_used = dim_used(value, MAX_COLS_DEF);
    else rows_used = dim_used(value, MAX_ROWS_DEF);
    col_pos  = 0;
    row_pos  = 0;
    left_sum = '0;
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    wait_idle();
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_GRID_ROWS, rows);
  endtask

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return COST_W'($urandom_range(0, 3));
      default: return COST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(11))
      0:       return '0;
      1:       return CFG_W'($urandom_range(256, 511));
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Corners, all-ones and alternating costs, zero sizes, restart mid-grid
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_cost(16'h0000);
    send_cost(16'hFFFF);
    set_grid(9'd0, 9'd3);
    send_cost(16'hFFFF);
    send_cost(16'hAAAA);
    send_cost(16'h5555);
    set_grid(9'd3, 9'd0);
    send_cost(16'h5555);
    send_cost(16'hAAAA);
    send_cost(16'hFFFF);
    set_grid(9'd3, 9'd2);
    send_cost(16'h0001);
    send_cost(16'h0002);
    send_cost(16'hFFFF);
    send_cost(16'h0002);
    wait_idle();
    write_reg(REG_GRID_ROWS, 9'd2);
    send_cost(16'h0004);
    send_cost(16'h0001);
    send_cost(16'h0000);
    send_cost(16'h0001);
    send_cost(16'h0003);
    send_cost(16'hFFFF);
  endtask

  task automatic test_wide_grid();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    set_grid(9'd256, 9'd2);
    repeat (512) send_cost(pick_cost());
  endtask

  // Single column: each sum is read back on the very next cell
  task automatic test_tall_grid();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(9'd1, 9'h1FF);
    repeat (256) send_cost(pick_cost());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(9'd8, 9'd8);
    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (200) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    repeat (40) send_cost(pick_cost());
    // pause the sender mid-grid until everything is back
    wait_idle();
    repeat (24) send_cost(pick_cost());
  endtask

  task automatic test_random_grids(input int sender_idle, input int receiver_idle,
                                   input int item_goal);
    int               sent;
    int               n_cells;
    int               n_send;
    logic             keep_rows;
    logic [CFG_W-1:0] cols_val;
    logic [CFG_W-1:0] rows_val;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    sent = 0;
    while (sent < item_goal) begin
      cols_val  = pick_dim();
      rows_val  = pick_dim();
      keep_rows = ($urandom_range(3) == 0) && (rows_used <= 12);
      if (dim_used(cols_val, MAX_COLS_DEF) *
          (keep_rows ? rows_used : dim_used(rows_val, MAX_ROWS_DEF)) > 300) begin
        keep_rows = 1'b0;
        rows_val  = CFG_W'($urandom_range(0, 1));
      end
      wait_idle();
      if (keep_rows) begin
        write_reg(REG_GRID_COLS, cols_val);
      end else if ($urandom_range(1)) begin
        write_reg(REG_GRID_ROWS, rows_val);
        write_reg(REG_GRID_COLS, cols_val);
      end else begin
        write_reg(REG_GRID_COLS, cols_val);
        write_reg(REG_GRID_ROWS, rows_val);
      end
      n_cells = cols_used * rows_used;
      case ($urandom_range(7))
        0:       n_send = $urandom_range(1, n_cells);
        1:       n_send = 2 * n_cells;
        default: n_send = n_cells;
      endcase
      repeat (n_send) send_cost(pick_cost());
      sent += n_send;
    end
  endtask

  always @(negedge clk) begin
    sums_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    path_result_t exp_res;
    if (!rst && sums_ch.valid && sums_ch.ready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual sum %h last %b sat %b",
                 $time, sums_ch.path_sum, sums_ch.last_cell, sums_ch.saturated);
      end else begin
        exp_res = pending_sums.pop_front();
        if (sums_ch.path_sum !== exp_res.sum) begin
          mismatches++;
          $display("%0t: path_sum mismatch: expected %h, actual %h",
                   $time, exp_res.sum, sums_ch.path_sum);
        end
        if (sums_ch.last_cell !== exp_res.last) begin
          mismatches++;
          $display("%0t: last_cell mismatch: expected %b, actual %b",
                   $time, exp_res.last, sums_ch.last_cell);
        end
        if (sums_ch.saturated !== exp_res.sat) begin
          mismatches++;
          $display("%0t: saturated mismatch: expected %b, actual %b",
                   $time, exp_res.sat, sums_ch.saturated);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_GRID_COLS;
    cfg_data           = '0;
    cells_ch.valid     = 1'b0;
    cells_ch.cell_cost = '0;
    sums_ch.ready      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_wide_grid();
    test_tall_grid();
    test_backpressure();
    test_random_grids(16, 59, 300);
    test_random_grids(59, 16, 300);
    test_random_grids(0, 0, 250);

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gmps_pkg.sv
hdl/gmps_if.sv
hdl/gmps_ram.sv
hdl/gmps_sum.sv
hdl/grid_min_path_sum.sv
sim/tb.sv
